// ===== src/interval_average_accumulator_assert.svh =====
// ---------------------------------------------------------------------------
// Interval average accumulator assertion macros
// Shared property templates for the port checker of the accumulator.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_AVERAGE_ACCUMULATOR_ASSERT_SVH
`define INTERVAL_AVERAGE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IAA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/iaa_pkg.sv =====
// ---------------------------------------------------------------------------
// Interval average accumulator package
// Widths, codes and the control state type shared by the accumulator files.
// ---------------------------------------------------------------------------
package iaa_pkg;

  localparam int SUM_WIDTH       = 48;
  localparam int COUNT_WIDTH     = 32;
  localparam int RES_WIDTH       = 48;
  localparam int SAMPLE_WIDTH    = 32;
  localparam int TIME_WIDTH      = 32;
  localparam int INTERVAL_WIDTH  = 16;
  localparam int MODE_WIDTH      = 2;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam int DIV_WIDTH  = (COUNT_WIDTH > INTERVAL_WIDTH) ? COUNT_WIDTH : INTERVAL_WIDTH;
  localparam int STEP_WIDTH = $clog2(SUM_WIDTH + 1);
  localparam int WIDE_WIDTH = (SUM_WIDTH > RES_WIDTH) ? SUM_WIDTH : RES_WIDTH;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [MODE_WIDTH-1:0] CALC_NONE = 2'd0;
  localparam logic [MODE_WIDTH-1:0] CALC_AVG  = 2'd1;
  localparam logic [MODE_WIDTH-1:0] CALC_SUM  = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INTERVAL = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE     = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ===== src/iaa_divider.sv =====
// ---------------------------------------------------------------------------
// Interval average accumulator serial divider
// Restoring divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
module iaa_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [iaa_pkg::SUM_WIDTH-1:0]     dividend,
  input  logic [iaa_pkg::DIV_WIDTH-1:0]     divisor,
  output logic                              done,
  output logic [iaa_pkg::SUM_WIDTH-1:0]     quotient,
  output logic [iaa_pkg::DIV_WIDTH-1:0]     remainder
);

  logic                              busy;
  logic [iaa_pkg::STEP_WIDTH-1:0]    steps;
  logic [iaa_pkg::DIV_WIDTH-1:0]     dvs;
  logic [iaa_pkg::DIV_WIDTH:0]       rem_shift;
  logic [iaa_pkg::DIV_WIDTH:0]       diff;
  logic                              take;

  assign rem_shift = {remainder, quotient[iaa_pkg::SUM_WIDTH-1]};
  assign diff      = rem_shift - {1'b0, dvs};
  assign take      = ~diff[iaa_pkg::DIV_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= iaa_pkg::STEP_WIDTH'(iaa_pkg::SUM_WIDTH);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == iaa_pkg::STEP_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[iaa_pkg::SUM_WIDTH-2:0], take};
      remainder <= take ? diff[iaa_pkg::DIV_WIDTH-1:0] : rem_shift[iaa_pkg::DIV_WIDTH-1:0];
    end
  end

endmodule

// ===== src/interval_average_accumulator.sv =====
// ---------------------------------------------------------------------------
// Interval average accumulator
// Sums signed samples and reports the average, sum or zero once per period.
// ---------------------------------------------------------------------------
// A sample is accumulated as it is taken, or, when the interval is zero,
// passes straight through the emit state to the output register. A tick
// runs the shared bit-serial divider once for the period check and, when
// it fires in average mode, once more for the quotient. Items are taken
// one at a time; a finished result sits in the output register while the
// next item is taken.
module interval_average_accumulator (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [iaa_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [iaa_pkg::CFG_DATA_WIDTH-1:0]       cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     op,
  input  logic signed [iaa_pkg::SAMPLE_WIDTH-1:0]  sample_value,
  input  logic [iaa_pkg::TIME_WIDTH-1:0]           now_seconds,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [iaa_pkg::RES_WIDTH-1:0]     result_value,
  output logic [iaa_pkg::TIME_WIDTH-1:0]           result_time
);

  localparam logic signed [iaa_pkg::SUM_WIDTH-1:0] SUM_MAX =
    {1'b0, {(iaa_pkg::SUM_WIDTH-1){1'b1}}};
  localparam logic signed [iaa_pkg::SUM_WIDTH-1:0] SUM_MIN =
    {1'b1, {(iaa_pkg::SUM_WIDTH-1){1'b0}}};
  localparam logic signed [iaa_pkg::WIDE_WIDTH-1:0] RES_HI =
    iaa_pkg::WIDE_WIDTH'({1'b0, {(iaa_pkg::RES_WIDTH-1){1'b1}}});
  localparam logic signed [iaa_pkg::WIDE_WIDTH-1:0] RES_LO = -RES_HI - 1;

  function automatic logic signed [iaa_pkg::RES_WIDTH-1:0] sat_res(
    input logic signed [iaa_pkg::SUM_WIDTH-1:0] v
  );
    logic signed [iaa_pkg::WIDE_WIDTH-1:0] wide;
    logic signed [iaa_pkg::WIDE_WIDTH-1:0] clamped;
    wide = iaa_pkg::WIDE_WIDTH'(v);
    if (wide > RES_HI) begin
      clamped = RES_HI;
    end else if (wide < RES_LO) begin
      clamped = RES_LO;
    end else begin
      clamped = wide;
    end
    return clamped[iaa_pkg::RES_WIDTH-1:0];
  endfunction

  iaa_pkg::state_t state;
  iaa_pkg::state_t state_next;

  logic [iaa_pkg::INTERVAL_WIDTH-1:0]      interval_seconds;
  logic [iaa_pkg::MODE_WIDTH-1:0]          calc_mode;
  logic signed [iaa_pkg::SUM_WIDTH-1:0]    running_sum;
  logic [iaa_pkg::COUNT_WIDTH-1:0]         sample_count;
  logic [iaa_pkg::TIME_WIDTH-1:0]          last_fire_second;
  logic [iaa_pkg::TIME_WIDTH-1:0]          now_q;
  logic                                    elapsed;
  logic                                    neg_q;
  logic signed [iaa_pkg::RES_WIDTH-1:0]    res_value;

  logic                                    in_fire;
  logic                                    div_start;
  logic [iaa_pkg::SUM_WIDTH-1:0]           div_dividend;
  logic [iaa_pkg::DIV_WIDTH-1:0]           div_divisor;
  logic                                    div_done;
  logic [iaa_pkg::SUM_WIDTH-1:0]           div_quotient;
  logic [iaa_pkg::DIV_WIDTH-1:0]           div_remainder;
  logic                                    fire_now;
  logic                                    out_load;
  logic signed [iaa_pkg::SUM_WIDTH:0]      sum_ext;
  logic signed [iaa_pkg::SUM_WIDTH-1:0]    sum_sat;
  logic [iaa_pkg::SUM_WIDTH-1:0]           sum_mag;
  logic signed [iaa_pkg::SUM_WIDTH-1:0]    avg_signed;
  logic                                    period_done;

  assign cfg_ready = 1'b1;

  iaa_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  assign sum_ext = (iaa_pkg::SUM_WIDTH+1)'(running_sum)
                   + (iaa_pkg::SUM_WIDTH+1)'(sample_value);

  always_comb begin
    if (sum_ext[iaa_pkg::SUM_WIDTH] != sum_ext[iaa_pkg::SUM_WIDTH-1]) begin
      sum_sat = sum_ext[iaa_pkg::SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[iaa_pkg::SUM_WIDTH-1:0];
    end
  end

  assign sum_mag     = running_sum[iaa_pkg::SUM_WIDTH-1] ? (~running_sum + 1'b1) : running_sum;
  assign avg_signed  = neg_q ? -div_quotient : div_quotient;
  assign fire_now    = (div_remainder == '0) || elapsed;
  assign period_done = ({1'b0, last_fire_second} + (iaa_pkg::TIME_WIDTH+1)'(interval_seconds))
                       <= {1'b0, now_seconds};

  always_comb begin
    in_stall     = (state != iaa_pkg::ST_IDLE);
    in_fire      = in_valid && (state == iaa_pkg::ST_IDLE);
    out_load     = (state == iaa_pkg::ST_EMIT) && (!out_valid || !out_stall);
    div_start    = 1'b0;
    div_dividend = iaa_pkg::SUM_WIDTH'(now_seconds);
    div_divisor  = iaa_pkg::DIV_WIDTH'(interval_seconds);
    if (state == iaa_pkg::ST_IDLE) begin
      div_start = in_fire && (op == iaa_pkg::OP_TICK) && (interval_seconds != '0)
                  && (last_fire_second != now_seconds);
    end else begin
      div_dividend = sum_mag;
      div_divisor  = iaa_pkg::DIV_WIDTH'(sample_count);
      div_start    = (state == iaa_pkg::ST_MOD) && div_done && fire_now
                     && (sample_count != '0) && (calc_mode == iaa_pkg::CALC_AVG);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iaa_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            iaa_pkg::OP_SAMPLE: begin
              if (interval_seconds == '0) begin
                state_next = iaa_pkg::ST_EMIT;
              end
            end
            iaa_pkg::OP_TICK: begin
              if ((interval_seconds != '0) && (last_fire_second != now_seconds)) begin
                state_next = iaa_pkg::ST_MOD;
              end
            end
            default: state_next = iaa_pkg::ST_IDLE;
          endcase
        end
      end
      iaa_pkg::ST_MOD: begin
        if (div_done) begin
          if (!fire_now || (sample_count == '0)) begin
            state_next = iaa_pkg::ST_IDLE;
          end else if (calc_mode == iaa_pkg::CALC_AVG) begin
            state_next = iaa_pkg::ST_DIV;
          end else begin
            state_next = iaa_pkg::ST_EMIT;
          end
        end
      end
      iaa_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = iaa_pkg::ST_EMIT;
        end
      end
      iaa_pkg::ST_EMIT: begin
        if (out_load) begin
          state_next = iaa_pkg::ST_IDLE;
        end
      end
      default: state_next = iaa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iaa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_seconds <= '0;
      calc_mode        <= iaa_pkg::CALC_AVG;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iaa_pkg::CFG_INTERVAL: interval_seconds <= cfg_data[iaa_pkg::INTERVAL_WIDTH-1:0];
        iaa_pkg::CFG_MODE:     calc_mode        <= cfg_data[iaa_pkg::MODE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= '0;
      sample_count     <= '0;
      last_fire_second <= '0;
    end else if (in_fire && (op == iaa_pkg::OP_SAMPLE) && (interval_seconds != '0)) begin
      running_sum <= sum_sat;
      if (sample_count != '1) begin
        sample_count <= sample_count + 1'b1;
      end
    end else if ((state == iaa_pkg::ST_MOD) && div_done && fire_now) begin
      last_fire_second <= now_q;
      running_sum      <= '0;
      sample_count     <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_q     <= now_seconds;
      elapsed   <= period_done;
      res_value <= iaa_pkg::RES_WIDTH'(sample_value);
    end else if ((state == iaa_pkg::ST_MOD) && div_done) begin
      neg_q <= running_sum[iaa_pkg::SUM_WIDTH-1];
      case (calc_mode)
        iaa_pkg::CALC_SUM:  res_value <= sat_res(running_sum);
        iaa_pkg::CALC_AVG:  res_value <= res_value;
        iaa_pkg::CALC_NONE: res_value <= '0;
        default:            res_value <= '0;
      endcase
    end else if ((state == iaa_pkg::ST_DIV) && div_done) begin
      res_value <= sat_res(avg_signed);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= res_value;
      result_time  <= now_q;
    end
  end

endmodule

// ===== src/iaa_checker.sv =====
// ---------------------------------------------------------------------------
// Interval average accumulator port checker
// Watches the ports of the accumulator for handshake and ordering rules.
// ---------------------------------------------------------------------------
`include "interval_average_accumulator_assert.svh"

module iaa_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     cfg_valid,
  input logic                                     cfg_ready,
  input logic                                     in_valid,
  input logic                                     in_stall,
  input logic                                     out_valid,
  input logic                                     out_stall,
  input logic signed [iaa_pkg::RES_WIDTH-1:0]     result_value,
  input logic [iaa_pkg::TIME_WIDTH-1:0]           result_time
);

  // A stalled result stays offered and unchanged.
  `IAA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
  `IAA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_value) && $stable(result_time), "stalled result changed")

  // A fresh result is only loaded after the block has stopped taking items.
  `IAA_ASSERT_SAME(a_rise_after_stall, $rose(out_valid), $past(in_stall), "result without a busy phase")

  // Configuration is always taken.
  `IAA_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration transfer refused")

endmodule

bind interval_average_accumulator iaa_checker u_iaa_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .result_time  (result_time)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval average accumulator testbench
// Drives samples and time ticks through the accumulator with random idle
// cycles and stalls on both sides. Each configuration phase is written while
// the block is idle. A scoreboard predicts every emitted value and its time,
// and checks each output transfer against the oldest prediction.
// ---------------------------------------------------------------------------

class accum_scoreboard;

  typedef struct {
    logic signed [iaa_pkg::RES_WIDTH-1:0] value;
    logic [iaa_pkg::TIME_WIDTH-1:0]       stamp;
  } reading_t;

  logic [iaa_pkg::INTERVAL_WIDTH-1:0] period;
  logic [iaa_pkg::MODE_WIDTH-1:0]     mode;
  longint                             run_sum;
  logic [iaa_pkg::COUNT_WIDTH-1:0]    count;
  logic [iaa_pkg::TIME_WIDTH-1:0]     last_fire;
  longint                             sum_hi, sum_lo, res_hi, res_lo;
  reading_t                           pending_q[$];
  int                                 errors;

  function new();
    sum_hi    = (longint'(1) <<< (iaa_pkg::SUM_WIDTH - 1)) - 1;
    sum_lo    = -sum_hi - 1;
    res_hi    = (longint'(1) <<< (iaa_pkg::RES_WIDTH - 1)) - 1;
    res_lo    = -res_hi - 1;
    period    = '0;
    mode      = iaa_pkg::CALC_AVG;
    run_sum   = 0;
    count     = '0;
    last_fire = '0;
    errors    = 0;
  endfunction

  function void write_reg(logic [iaa_pkg::CFG_INDEX_WIDTH-1:0] idx,
                          logic [iaa_pkg::CFG_DATA_WIDTH-1:0] data);
    if (idx == iaa_pkg::CFG_INTERVAL) begin
      period = data[iaa_pkg::INTERVAL_WIDTH-1:0];
    end else if (idx == iaa_pkg::CFG_MODE) begin
      mode = data[iaa_pkg::MODE_WIDTH-1:0];
    end
  endfunction

  function void push_reading(longint v, logic [iaa_pkg::TIME_WIDTH-1:0] t);
    reading_t e;
    if (v > res_hi) begin
      v = res_hi;
    end else if (v < res_lo) begin
      v = res_lo;
    end
    e.value = v[iaa_pkg::RES_WIDTH-1:0];
    e.stamp = t;
    pending_q.push_back(e);
  endfunction

  function void note_input(logic o, logic signed [iaa_pkg::SAMPLE_WIDTH-1:0] v,
                           logic [iaa_pkg::TIME_WIDTH-1:0] t);
    longint s;
    longint r;
    s = v;
    if (o == iaa_pkg::OP_SAMPLE) begin
      if (period == 0) begin
        push_reading(s, t);
      end else begin
        s = run_sum + s;
        if (s > sum_hi) begin
          s = sum_hi;
        end else if (s < sum_lo) begin
          s = sum_lo;
        end
        run_sum = s;
        if (count != '1) begin
          count++;
        end
      end
    end else if (period != 0 && last_fire != t &&
                 (longint'(t) % longint'(period) == 0 ||
                  longint'(last_fire) + longint'(period) <= longint'(t))) begin
      last_fire = t;
      if (count != 0) begin
        if (mode == iaa_pkg::CALC_AVG) begin
          r = run_sum / longint'(count);
        end else if (mode == iaa_pkg::CALC_SUM) begin
          r = run_sum;
        end else begin
          r = 0;
        end
        run_sum = 0;
        count   = '0;
        push_reading(r, t);
      end
    end
  endfunction

  task report(string what);
    $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task check_result(logic signed [iaa_pkg::RES_WIDTH-1:0] v,
                    logic [iaa_pkg::TIME_WIDTH-1:0] t);
    reading_t e;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result value %0d second %0d", v, t));
      return;
    end
    e = pending_q.pop_front();
    if (v !== e.value) begin
      report($sformatf("result_value %0d, predicted %0d", v, e.value));
    end
    if (t !== e.stamp) begin
      report($sformatf("result_time %0d, predicted %0d", t, e.stamp));
    end
  endtask

endclass

module testbench;

  localparam int DRAIN_CYCLES     = 2 * iaa_pkg::SUM_WIDTH + 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int ITEM_TARGET      = 1650;
  localparam int QUIET_TAIL       = 200;
  localparam logic [iaa_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 8'hff;
  localparam logic [iaa_pkg::MODE_WIDTH-1:0]      CALC_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [iaa_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [iaa_pkg::CFG_DATA_WIDTH-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic op;
  logic signed [iaa_pkg::SAMPLE_WIDTH-1:0] sample_value;
  logic [iaa_pkg::TIME_WIDTH-1:0] now_seconds;
  logic out_valid;
  logic out_stall;
  logic signed [iaa_pkg::RES_WIDTH-1:0] result_value;
  logic [iaa_pkg::TIME_WIDTH-1:0] result_time;

  accum_scoreboard sb;
  int sent_items;
  int send_gap_pct;
  int recv_stall_pct;
  logic quiet;
  logic long_hold;

  int phase;
  int phase_len;
  int pick;
  logic [iaa_pkg::INTERVAL_WIDTH-1:0] iv;
  logic [iaa_pkg::MODE_WIDTH-1:0] md;
  logic signed [iaa_pkg::SAMPLE_WIDTH-1:0] next_value;
  logic [iaa_pkg::TIME_WIDTH-1:0] clock_second;

  interval_average_accumulator uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .sample_value(sample_value),
    .now_seconds(now_seconds),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .result_time(result_time)
  );

  always #5 clk = ~clk;

  task send_item(logic o, logic signed [iaa_pkg::SAMPLE_WIDTH-1:0] v,
                 logic [iaa_pkg::TIME_WIDTH-1:0] t);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     = 1'b1;
    op           = o;
    sample_value = v;
    now_seconds  = t;
    do @(posedge clk); while (in_stall);
    sb.note_input(o, v, t);
    sent_items++;
  endtask

  task drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_cfg(logic [iaa_pkg::CFG_INDEX_WIDTH-1:0] idx,
                 logic [iaa_pkg::CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      sb.check_result(result_value, result_time);
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < recv_stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb             = new();
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    op             = iaa_pkg::OP_SAMPLE;
    sample_value   = '0;
    now_seconds    = '0;
    sent_items     = 0;
    send_gap_pct   = 15;
    recv_stall_pct = 15;
    quiet          = 1'b0;
    long_hold      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Pass-through straight after reset, then a period of four seconds.
    send_item(iaa_pkg::OP_SAMPLE, 32'sh7fffffff, 32'd0);
    send_item(iaa_pkg::OP_SAMPLE, 32'sh80000000, 32'hffffffff);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd5);
    send_item(iaa_pkg::OP_SAMPLE, -32'sd1, 32'd123);
    drain;
    write_cfg(iaa_pkg::CFG_INTERVAL, 16'd4);
    send_item(iaa_pkg::OP_SAMPLE, -32'sd7, 32'd1);
    send_item(iaa_pkg::OP_SAMPLE, 32'sd2, 32'd2);
    send_item(iaa_pkg::OP_TICK, 32'shffffffff, 32'd8);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd8);
    send_item(iaa_pkg::OP_SAMPLE, 32'sd10, 32'd9);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd9);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd12);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd16);
    send_item(iaa_pkg::OP_SAMPLE, 32'sd5, 32'd16);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd17);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd20);
    send_item(iaa_pkg::OP_SAMPLE, 32'sh7fffffff, 32'd21);
    send_item(iaa_pkg::OP_SAMPLE, 32'sh7fffffff, 32'd21);
    send_item(iaa_pkg::OP_SAMPLE, 32'sh80000000, 32'd22);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'hffffffff);
    drain;
    write_cfg(iaa_pkg::CFG_MODE, 16'(iaa_pkg::CALC_SUM));
    send_item(iaa_pkg::OP_SAMPLE, 32'sd100, 32'd0);
    send_item(iaa_pkg::OP_SAMPLE, -32'sd300, 32'd1);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd3);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd4);
    drain;
    write_cfg(iaa_pkg::CFG_MODE, 16'(CALC_SPARE));
    send_item(iaa_pkg::OP_SAMPLE, 32'sd42, 32'd5);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd8);
    drain;
    write_cfg(iaa_pkg::CFG_MODE, 16'(iaa_pkg::CALC_NONE));
    write_cfg(iaa_pkg::CFG_INTERVAL, 16'hffff);
    send_item(iaa_pkg::OP_SAMPLE, -32'sd9, 32'd6);
    send_item(iaa_pkg::OP_TICK, 32'sh0, 32'd131070);
    drain;

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      if (phase == 0) begin
        iv = '0;
        md = iaa_pkg::CALC_AVG;
      end else if (phase == 1) begin
        iv = 16'd1;
        md = iaa_pkg::CALC_AVG;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          iv = '0;
        end else if (pick == 1) begin
          iv = 16'hffff;
        end else if (pick == 2) begin
          iv = 16'($urandom);
        end else begin
          iv = 16'($urandom_range(1, 12));
        end
        md = 2'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 1) == 0) begin
        write_cfg(iaa_pkg::CFG_INTERVAL, iv);
        write_cfg(iaa_pkg::CFG_MODE, {14'($urandom), md});
      end else begin
        write_cfg(iaa_pkg::CFG_MODE, {14'($urandom), md});
        write_cfg(iaa_pkg::CFG_INTERVAL, iv);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_cfg(CFG_UNUSED, 16'($urandom));
      end
      send_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 15;
      recv_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
      // The receiver holds off so that pass-through results back up into the input.
      if (phase == 0) begin
        long_hold = 1'b1;
      end
      case ($urandom_range(0, 3))
        0: clock_second = $urandom;
        1: clock_second = 32'hffffffff - $urandom_range(0, 400);
        2: clock_second = $urandom_range(0, 50);
        default: clock_second = $urandom_range(0, 100000);
      endcase
      phase_len = $urandom_range(60, 160);
      for (int k = 0; k < phase_len && sent_items < ITEM_TARGET; k++) begin
        quiet = (sent_items >= ITEM_TARGET - QUIET_TAIL);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_item(1'($urandom), $urandom, $urandom);
        end else if (pick < 70) begin
          case ($urandom_range(0, 7))
            0: next_value = 32'sh7fffffff;
            1: next_value = 32'sh80000000;
            2, 3: next_value = $urandom_range(0, 2000) - 1000;
            default: next_value = $urandom;
          endcase
          send_item(iaa_pkg::OP_SAMPLE, next_value, clock_second);
        end else begin
          if (iv != 0 && $urandom_range(0, 5) == 0) begin
            clock_second = (clock_second / iv + 1) * iv;
          end else begin
            clock_second = clock_second + $urandom_range(0, 2);
          end
          send_item(iaa_pkg::OP_TICK, $urandom, clock_second);
        end
      end
      drain;
      phase++;
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
